@@ hdl/ptst_pkg.sv @@
// Shared constants, codes and types of the packet type statistics table.
package ptst_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W   = 32;
  localparam int REF_W   = 16;
  localparam int CNT_W   = 32;
  localparam int NCNT    = 5;
  localparam int LANE_W  = 3;
  localparam int INC_W   = 16;

  localparam logic [REF_W-1:0] REF_MAX = '1;

  // Operation codes carried by in_kind.
  localparam logic [2:0] KIND_ADD     = 3'd0;
  localparam logic [2:0] KIND_REMOVE  = 3'd1;
  localparam logic [2:0] KIND_ACCOUNT = 3'd2;
  localparam logic [2:0] KIND_QUERY   = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  // Counter lanes inside an entry.
  localparam logic [LANE_W-1:0] LANE_PKT_SENT  = 3'd0;
  localparam logic [LANE_W-1:0] LANE_PKT_RECV  = 3'd1;
  localparam logic [LANE_W-1:0] LANE_BYTE_SENT = 3'd2;
  localparam logic [LANE_W-1:0] LANE_BYTE_RECV = 3'd3;
  localparam logic [LANE_W-1:0] LANE_PKT_DROP  = 3'd4;

  typedef struct packed {
    logic [REF_W-1:0]            refcount;
    logic [NCNT-1:0][CNT_W-1:0]  cnt;
  } entry_data_t;

  // Commands from the sequencer to the key scanner.
  typedef struct packed {
    logic             start;
    logic             alloc;
    logic             release_slot;
    logic             clear_all;
    logic [IDX_W-1:0] idx;
  } tbl_ctl_t;

  // Scan outcome, valid while done is high.
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic             free_ok;
    logic [IDX_W-1:0] free_slot;
  } scan_res_t;

endpackage

@@ hdl/ptst_scan.sv @@
// Key store, valid bits and one-entry-per-cycle key comparator.
module ptst_scan import ptst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tbl_ctl_t         ctl,
  input  logic [KEY_W-1:0] key,
  output scan_res_t        res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [KEY_W-1:0] key_q_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  logic             rd_busy_r, rd_busy_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             cmp_live_r, cmp_live_nxt;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic cmp_hit;
  logic cmp_free;
  logic done;

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.alloc) begin
      key_mem[ctl.idx] <= key;
    end
    key_q_r   <= key_mem[rd_idx_r];
    cmp_idx_r <= rd_idx_r;
  end

  assign cmp_hit  = cmp_live_r && valid_r[cmp_idx_r] && (key_q_r == key);
  assign cmp_free = cmp_live_r && !valid_r[cmp_idx_r];
  assign done     = cmp_live_r && (cmp_hit || (cmp_idx_r == LAST_IDX));

  always_comb begin
    res.done      = done;
    res.hit       = cmp_hit;
    res.slot      = cmp_idx_r;
    res.free_ok   = free_found_r || cmp_free;
    res.free_slot = free_found_r ? free_idx_r : cmp_idx_r;
  end

  always_comb begin
    rd_busy_nxt    = rd_busy_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_live_nxt   = rd_busy_r && !done;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    if (ctl.start) begin
      rd_busy_nxt    = 1'b1;
      rd_idx_nxt     = '0;
      cmp_live_nxt   = 1'b0;
      free_found_nxt = 1'b0;
    end else begin
      if (cmp_free && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = cmp_idx_r;
      end
      if (done) begin
        rd_busy_nxt = 1'b0;
      end else if (rd_busy_r) begin
        if (rd_idx_r == LAST_IDX) begin
          rd_busy_nxt = 1'b0;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clear_all) begin
      valid_nxt = '0;
    end else if (ctl.alloc) begin
      valid_nxt[ctl.idx] = 1'b1;
    end else if (ctl.release_slot) begin
      valid_nxt[ctl.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      rd_busy_r    <= 1'b0;
      rd_idx_r     <= '0;
      cmp_live_r   <= 1'b0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
    end else begin
      valid_r      <= valid_nxt;
      rd_busy_r    <= rd_busy_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cmp_live_r   <= cmp_live_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
    end
  end

  a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res.done && res.hit |-> valid_r[res.slot])
    else $error("scan hit on a free entry");

  a_free_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.done && !res.hit && res.free_ok |-> !valid_r[res.free_slot])
    else $error("free slot reported on a used entry");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |=> !res.done)
    else $error("scan done held for two cycles");

endmodule

@@ hdl/packet_type_stats_table.sv @@
// Top level of the packet type statistics table: sequencer, entry data store, shared adder.
//
//  channel   direction  handshake               payload
//  in_*      input      in_valid / in_stall     kind, packet_type, five increments
//  out_*     output     out_valid / out_stall   ok, five 32-bit counters
//
//  One item at a time. Add, remove, account and query scan the key store one
//  entry a cycle. On a hit the entry is read; account passes its counters
//  through one 32-bit adder, one counter per cycle, add or remove passes the
//  reference count through it, and the entry is written back unless a remove
//  drops it. Clear and unused kinds answer without a scan. in_stall stays high
//  from accept until the result is taken; a stalled result holds in the output
//  registers. Reset clears all valid bits at once; no clearing pass.
module packet_type_stats_table import ptst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_kind,
  input  logic [KEY_W-1:0] in_packet_type,
  input  logic [7:0]       in_add_packets_sent,
  input  logic [7:0]       in_add_packets_received,
  input  logic [15:0]      in_add_bytes_sent,
  input  logic [15:0]      in_add_bytes_received,
  input  logic [7:0]       in_add_packets_dropped,

  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_ok,
  output logic [CNT_W-1:0] out_packets_sent,
  output logic [CNT_W-1:0] out_packets_received,
  output logic [CNT_W-1:0] out_bytes_sent,
  output logic [CNT_W-1:0] out_bytes_received,
  output logic [CNT_W-1:0] out_packets_dropped
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_READ = 6'b000100,
    S_LOAD = 6'b001000,
    S_UPDT = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  // Result wait is its own flag so the response path stays simple.
  state_t state_r, state_nxt;
  logic   resp_r, resp_nxt;

  logic [2:0]                 kind_r;
  logic [KEY_W-1:0]           key_r;
  logic [NCNT-1:0][INC_W-1:0] inc_r;
  logic [IDX_W-1:0]           slot_r, slot_nxt;
  logic [LANE_W-1:0]          lane_r, lane_nxt;
  entry_data_t                work_r, work_nxt;
  entry_data_t                data_q_r;
  entry_data_t                data_mem [ENTRIES];
  logic                       wb_en;

  logic                       ok_r, ok_nxt;
  logic [NCNT-1:0][CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  tbl_ctl_t  ctl;
  scan_res_t scan_res;

  logic             is_account;
  logic [CNT_W-1:0] op_a, op_b, sum;
  logic             accept;

  assign accept = in_valid && !in_stall;

  ptst_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .key   (key_r),
    .res   (scan_res)
  );

  // Entry data memory: write back from the work register, registered read at slot_r.
  always_ff @(posedge clk) begin
    if (wb_en) begin
      data_mem[slot_r] <= work_r;
    end
    data_q_r <= data_mem[slot_r];
  end

  // Shared adder: counter lanes for account, refcount +1 / -1 for add and remove.
  assign is_account = (kind_r == KIND_ACCOUNT);
  always_comb begin
    if (is_account) begin
      op_a = work_r.cnt[lane_r];
      op_b = {{(CNT_W-INC_W){1'b0}}, inc_r[lane_r]};
    end else begin
      op_a = {{(CNT_W-REF_W){1'b0}}, work_r.refcount};
      op_b = (kind_r == KIND_ADD) ? CNT_W'(1) : '1;
    end
    sum = op_a + op_b;
  end

  always_comb begin
    state_nxt   = state_r;
    resp_nxt    = resp_r;
    slot_nxt    = slot_r;
    lane_nxt    = lane_r;
    work_nxt    = work_r;
    ok_nxt      = ok_r;
    res_cnt_nxt = res_cnt_r;
    wb_en       = 1'b0;
    ctl         = '0;
    ctl.idx     = slot_r;

    case (state_r)
      S_IDLE: begin
        if (resp_r) begin
          // Hold the result until the consumer takes it.
          if (!out_stall) begin
            resp_nxt = 1'b0;
          end
        end else if (accept) begin
          ok_nxt      = 1'b0;
          res_cnt_nxt = '0;
          case (in_kind)
            KIND_ADD, KIND_REMOVE, KIND_ACCOUNT, KIND_QUERY: begin
              ctl.start = 1'b1;
              state_nxt = S_SCAN;
            end
            KIND_CLEAR: begin
              ctl.clear_all = 1'b1;
              ok_nxt        = 1'b1;
              resp_nxt      = 1'b1;
            end
            default: begin
              resp_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            slot_nxt  = scan_res.slot;
            state_nxt = S_READ;
          end else if (kind_r == KIND_ADD && scan_res.free_ok) begin
            // Claim the lowest free entry with zeroed counters.
            slot_nxt          = scan_res.free_slot;
            ctl.alloc         = 1'b1;
            ctl.idx           = scan_res.free_slot;
            work_nxt.refcount = REF_W'(1);
            work_nxt.cnt      = '0;
            state_nxt         = S_WB;
          end else begin
            state_nxt = S_IDLE;
            resp_nxt  = 1'b1;
          end
        end
      end

      S_READ: begin
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        if (kind_r == KIND_QUERY) begin
          ok_nxt      = 1'b1;
          res_cnt_nxt = data_q_r.cnt;
          state_nxt   = S_IDLE;
          resp_nxt    = 1'b1;
        end else begin
          work_nxt  = data_q_r;
          lane_nxt  = LANE_PKT_SENT;
          state_nxt = S_UPDT;
        end
      end

      S_UPDT: begin
        case (kind_r)
          KIND_ACCOUNT: begin
            work_nxt.cnt[lane_r] = sum;
            if (lane_r == LANE_PKT_DROP) begin
              state_nxt = S_WB;
            end else begin
              lane_nxt = lane_r + 1'b1;
            end
          end
          KIND_ADD: begin
            // Saturate the reference count.
            if (work_r.refcount != REF_MAX) begin
              work_nxt.refcount = sum[REF_W-1:0];
            end
            state_nxt = S_WB;
          end
          KIND_REMOVE: begin
            if (work_r.refcount <= REF_W'(1)) begin
              // Drop the entry; its data is dead until the next claim.
              ctl.release_slot = 1'b1;
              ok_nxt           = 1'b1;
              state_nxt        = S_IDLE;
              resp_nxt         = 1'b1;
            end else begin
              work_nxt.refcount = sum[REF_W-1:0];
              state_nxt         = S_WB;
            end
          end
          default: begin
            state_nxt = S_IDLE;
            resp_nxt  = 1'b1;
          end
        endcase
      end

      S_WB: begin
        wb_en     = 1'b1;
        ok_nxt    = 1'b1;
        state_nxt = S_IDLE;
        resp_nxt  = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
        resp_nxt  = 1'b0;
      end
    endcase
  end

  // Latch the item at accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r                 <= in_kind;
      key_r                  <= in_packet_type;
      inc_r[LANE_PKT_SENT]   <= {8'd0, in_add_packets_sent};
      inc_r[LANE_PKT_RECV]   <= {8'd0, in_add_packets_received};
      inc_r[LANE_BYTE_SENT]  <= in_add_bytes_sent;
      inc_r[LANE_BYTE_RECV]  <= in_add_bytes_received;
      inc_r[LANE_PKT_DROP]   <= {8'd0, in_add_packets_dropped};
    end
    slot_r    <= slot_nxt;
    lane_r    <= lane_nxt;
    work_r    <= work_nxt;
    res_cnt_r <= res_cnt_nxt;
    ok_r      <= ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  assign in_stall             = (state_r != S_IDLE) || resp_r;
  assign out_valid            = resp_r;
  assign out_ok               = ok_r;
  assign out_packets_sent     = res_cnt_r[LANE_PKT_SENT];
  assign out_packets_received = res_cnt_r[LANE_PKT_RECV];
  assign out_bytes_sent       = res_cnt_r[LANE_BYTE_SENT];
  assign out_bytes_received   = res_cnt_r[LANE_BYTE_RECV];
  assign out_packets_dropped  = res_cnt_r[LANE_PKT_DROP];

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> state_r == S_SCAN)
    else $error("scan finished outside the scan state");

  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second item accepted before the result");

  a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPDT |-> lane_r <= LANE_PKT_DROP)
    else $error("counter lane out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> res_cnt_r == '0)
    else $error("nonzero counters on a failed item");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the packet type statistics table.
module tb;
  import ptst_pkg::*;

  // Kind codes that the block must ignore.
  localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

  // Stimulus plan: a directed table, then a random mix.
  localparam int N_DIRECTED    = 25;
  localparam int N_RANDOM      = 1500;
  localparam int N_MIXED       = N_DIRECTED + N_RANDOM;
  localparam int N_TOTAL       = N_MIXED;

  // Worst item: full key scan, five adder passes, read and write-back, plus
  // the longest random gap and stall; CYCLE_LIMIT leaves ample room per item.
  localparam int CYCLE_LIMIT   = N_TOTAL * 200;
  localparam int DRAIN_CYCLES  = 4 * (ENTRIES + 8);
  localparam int KEY_POOL      = 20;

  typedef struct packed {
    logic [2:0]       kind;
    logic [KEY_W-1:0] ptype;
    logic [7:0]       inc_pkt_sent;
    logic [7:0]       inc_pkt_recv;
    logic [15:0]      inc_byte_sent;
    logic [15:0]      inc_byte_recv;
    logic [7:0]       inc_pkt_drop;
  } op_item_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] pkt_sent;
    logic [CNT_W-1:0] pkt_recv;
    logic [CNT_W-1:0] byte_sent;
    logic [CNT_W-1:0] byte_recv;
    logic [CNT_W-1:0] pkt_drop;
  } stat_result_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] refs;
    logic [CNT_W-1:0] pkt_sent;
    logic [CNT_W-1:0] pkt_recv;
    logic [CNT_W-1:0] byte_sent;
    logic [CNT_W-1:0] byte_recv;
    logic [CNT_W-1:0] pkt_drop;
  } stat_entry_t;

  // typed = 1: the row carries its own expected result; otherwise the
  // shadow table decides.
  typedef struct packed {
    op_item_t     op;
    logic         typed;
    stat_result_t want;
  } directed_row_t;

  localparam stat_result_t MISS     = '0;
  localparam stat_result_t HIT      = '{ok: 1'b1, default: '0};
  localparam stat_result_t HIT_MAX  = '{1'b1, 32'd255, 32'd255, 32'd65535, 32'd65535, 32'd255};
  localparam stat_result_t HIT_STEP = '{1'b1, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5};

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Empty table after reset: every lookup misses, spare kinds do nothing.
    '{'{KIND_QUERY,     32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, MISS},
    '{'{KIND_REMOVE,    32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, MISS},
    '{'{KIND_ACCOUNT,   32'h0000_0000, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, MISS},
    '{'{KIND_SPARE_LO,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, MISS},
    '{'{KIND_SPARE_MID, 32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, MISS},
    '{'{KIND_SPARE_HI,  32'hA5A5_5A5A, 8'hA5, 8'h5A, 16'hA55A, 16'h5AA5, 8'hC3}, 1'b1, MISS},
    // Extreme keys claim the two lowest slots; add ignores the increments.
    '{'{KIND_ADD,       32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, HIT},
    '{'{KIND_ADD,       32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, HIT},
    '{'{KIND_ACCOUNT,   32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, HIT},
    '{'{KIND_QUERY,     32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, HIT_MAX},
    '{'{KIND_ACCOUNT,   32'h0000_0000, 8'h01, 8'h02, 16'h0003, 16'h0004, 8'h05}, 1'b1, HIT},
    '{'{KIND_QUERY,     32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, HIT_STEP},
    // Reference count up to 2, then down to zero frees the slot.
    '{'{KIND_ADD,       32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, MISS},
    '{'{KIND_REMOVE,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, MISS},
    '{'{KIND_QUERY,     32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, MISS},
    '{'{KIND_REMOVE,    32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, MISS},
    '{'{KIND_QUERY,     32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, MISS},
    // A new type reuses the freed lowest slot; a stranger still misses.
    '{'{KIND_ADD,       32'h1234_5678, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, MISS},
    '{'{KIND_QUERY,     32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, MISS},
    '{'{KIND_ACCOUNT,   32'hA5A5_5A5A, 8'h11, 8'h22, 16'h3333, 16'h4444, 8'h55}, 1'b0, MISS},
    // Clear drops everything; a re-added type starts from zeroed counters.
    '{'{KIND_CLEAR,     32'h0000_0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, HIT},
    '{'{KIND_QUERY,     32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, MISS},
    '{'{KIND_QUERY,     32'h1234_5678, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b1, MISS},
    '{'{KIND_ADD,       32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, MISS},
    '{'{KIND_QUERY,     32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00}, 1'b0, MISS}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_kind;
  logic [KEY_W-1:0] in_packet_type;
  logic [7:0]       in_add_packets_sent;
  logic [7:0]       in_add_packets_received;
  logic [15:0]      in_add_bytes_sent;
  logic [15:0]      in_add_bytes_received;
  logic [7:0]       in_add_packets_dropped;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_ok;
  logic [CNT_W-1:0] out_packets_sent;
  logic [CNT_W-1:0] out_packets_received;
  logic [CNT_W-1:0] out_bytes_sent;
  logic [CNT_W-1:0] out_bytes_received;
  logic [CNT_W-1:0] out_packets_dropped;

  // Shadow copy of the table, updated at each accepted item.
  stat_entry_t      stats [ENTRIES];
  stat_result_t     expected_results [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int               accept_count   = 0;
  int               mismatch_count = 0;
  int               issue_idx      = 0;
  int               cycle_count    = 0;

  packet_type_stats_table dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_kind                 (in_kind),
    .in_packet_type          (in_packet_type),
    .in_add_packets_sent     (in_add_packets_sent),
    .in_add_packets_received (in_add_packets_received),
    .in_add_bytes_sent       (in_add_bytes_sent),
    .in_add_bytes_received   (in_add_bytes_received),
    .in_add_packets_dropped  (in_add_packets_dropped),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_ok                  (out_ok),
    .out_packets_sent        (out_packets_sent),
    .out_packets_received    (out_packets_received),
    .out_bytes_sent          (out_bytes_sent),
    .out_bytes_received      (out_bytes_received),
    .out_packets_dropped     (out_packets_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // Lowest valid slot holding the key, or -1.
  function automatic int find_type(logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (stats[i].valid && stats[i].key == key) return i;
    end
    return -1;
  endfunction

  // Lowest free slot, or -1 when the table is full.
  function automatic int first_free();
    for (int i = 0; i < ENTRIES; i++) begin
      if (!stats[i].valid) return i;
    end
    return -1;
  endfunction

  // Apply one item to the shadow table and return the result it must give.
  function automatic stat_result_t apply_table_op(op_item_t op);
    stat_result_t res;
    int           slot;
    res  = '0;
    slot = find_type(op.ptype);
    case (op.kind)
      KIND_ADD: begin
        if (slot >= 0) begin
          // Saturate the count; the add still succeeds.
          if (stats[slot].refs != REF_MAX) stats[slot].refs = stats[slot].refs + 1'b1;
          res.ok = 1'b1;
        end else begin
          slot = first_free();
          if (slot >= 0) begin
            stats[slot]       = '0;
            stats[slot].valid = 1'b1;
            stats[slot].key   = op.ptype;
            stats[slot].refs  = 16'd1;
            res.ok            = 1'b1;
          end
        end
      end
      KIND_REMOVE: begin
        if (slot >= 0) begin
          if (stats[slot].refs <= 16'd1) begin
            stats[slot].refs  = '0;
            stats[slot].valid = 1'b0;
          end else begin
            stats[slot].refs = stats[slot].refs - 1'b1;
          end
          res.ok = 1'b1;
        end
      end
      KIND_ACCOUNT: begin
        if (slot >= 0) begin
          // Counters wrap at 32 bits.
          stats[slot].pkt_sent  = stats[slot].pkt_sent + op.inc_pkt_sent;
          stats[slot].pkt_recv  = stats[slot].pkt_recv + op.inc_pkt_recv;
          stats[slot].byte_sent = stats[slot].byte_sent + op.inc_byte_sent;
          stats[slot].byte_recv = stats[slot].byte_recv + op.inc_byte_recv;
          stats[slot].pkt_drop  = stats[slot].pkt_drop + op.inc_pkt_drop;
          res.ok = 1'b1;
        end
      end
      KIND_QUERY: begin
        if (slot >= 0) begin
          res = '{1'b1, stats[slot].pkt_sent, stats[slot].pkt_recv,
                  stats[slot].byte_sent, stats[slot].byte_recv, stats[slot].pkt_drop};
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) stats[i].valid = 1'b0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly random, with a fair share of all-ones and zero.
  function automatic logic [7:0] rand_inc8();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'hFF;
    if (roll == 1) return 8'h00;
    return 8'($urandom());
  endfunction

  function automatic logic [15:0] rand_inc16();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return 16'hFFFF;
    if (roll == 1) return 16'h0000;
    return 16'($urandom());
  endfunction

  // Adds outweigh removes and the key pool exceeds ENTRIES, so the table
  // fills up and add-to-full shows up regularly between the rare clears.
  function automatic op_item_t random_op();
    op_item_t    op;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 36)      op.kind = KIND_ADD;
    else if (roll < 53) op.kind = KIND_REMOVE;
    else if (roll < 76) op.kind = KIND_ACCOUNT;
    else if (roll < 96) op.kind = KIND_QUERY;
    else if (roll < 97) op.kind = KIND_CLEAR;
    else                op.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    if ($urandom_range(99) < 6) op.ptype = $urandom();
    else                        op.ptype = key_pool[$urandom_range(KEY_POOL - 1)];
    // Refresh the random part of the pool once the table is empty again.
    if (op.kind == KIND_CLEAR) begin
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();
    end
    op.inc_pkt_sent  = rand_inc8();
    op.inc_pkt_recv  = rand_inc8();
    op.inc_byte_sent = rand_inc16();
    op.inc_byte_recv = rand_inc16();
    op.inc_pkt_drop  = rand_inc8();
    return op;
  endfunction

  function automatic op_item_t next_op(int idx);
    if (idx < N_DIRECTED) return DIRECTED_ROWS[idx].op;
    return random_op();
  endfunction

  // Idle profile: sender dense / receiver busy, then swapped, then none.
  function automatic int phase_of(int idx);
    if (idx < N_MIXED / 3)     return 0;
    if (idx < 2 * N_MIXED / 3) return 1;
    return 2;
  endfunction

  function automatic int send_idle_pct(int idx);
    case (phase_of(idx))
      0:       return 13;
      1:       return 75;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(int idx);
    case (phase_of(idx))
      0:       return 75;
      1:       return 13;
      default: return 0;
    endcase
  endfunction

  // Drive items and finish the run.
  initial begin
    op_item_t op;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    {in_kind, in_packet_type, in_add_packets_sent, in_add_packets_received,
     in_add_bytes_sent, in_add_bytes_received, in_add_packets_dropped} <= '0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    // Keep the extreme keys in the pool.
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int idx = 0; idx < N_TOTAL; idx++) begin
      op = next_op(idx);
      // Insert an idle gap before the item while the roll falls under the idle share.
      while ($urandom_range(99) < send_idle_pct(idx)) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      issue_idx <= idx;
      in_valid  <= 1'b1;
      {in_kind, in_packet_type, in_add_packets_sent, in_add_packets_received,
       in_add_bytes_sent, in_add_bytes_received, in_add_packets_dropped} <= op;
      // Hold the item until an edge takes it.
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    // Let the monitor record the last item, drain, then watch for strays.
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver back-pressure, following the sender's current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct(issue_idx));
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string field, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
    end
  endfunction

  // Sample both channels at the clock edge: record expectations on accept,
  // compare results in order on delivery.
  always @(posedge clk) begin
    op_item_t     seen;
    stat_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) stats[i] = '0;
    end else begin
      if (in_valid && !in_stall) begin
        seen = {in_kind, in_packet_type, in_add_packets_sent, in_add_packets_received,
                in_add_bytes_sent, in_add_bytes_received, in_add_packets_dropped};
        want = apply_table_op(seen);
        // Directed rows with a written-in answer take precedence.
        if (accept_count < N_DIRECTED && DIRECTED_ROWS[accept_count].typed)
          want = DIRECTED_ROWS[accept_count].want;
        expected_results.push_back(want);
        accept_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $error("out_ok: expected no result, got 0x%0h", out_ok);
        end else begin
          want = expected_results.pop_front();
          check_field("out_ok",               CNT_W'(want.ok), CNT_W'(out_ok));
          check_field("out_packets_sent",     want.pkt_sent,   out_packets_sent);
          check_field("out_packets_received", want.pkt_recv,   out_packets_received);
          check_field("out_bytes_sent",       want.byte_sent,  out_bytes_sent);
          check_field("out_bytes_received",   want.byte_recv,  out_bytes_received);
          check_field("out_packets_dropped",  want.pkt_drop,   out_packets_dropped);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
